FILE: sv/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Types and constants shared by the ordered list store controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package ols_pkg;

	localparam int CAPACITY = 128;

	// fixed field widths
	localparam int ACT_W  = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;
	localparam int FIDX_W = 7;
	localparam int LEN_W  = 8;

	// derived storage widths
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_GET    = 3'd0,
		ACT_LOCATE = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_GET_WAIT,
		S_SCAN,
		S_INS,
		S_INS_DRAIN,
		S_INS_VAL,
		S_DEL,
		S_DEL_DRAIN,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_TOP,
		PTR_NEXT,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    rd_en;
		logic    rd_sel_pos;
		ptr_op_t ptr_op;
		logic    wr_shift;
		logic    wr_up;
		logic    wr_val;
		cnt_op_t cnt_op;
		logic    set_status;
		status_t status;
		logic    cap_read;
		logic    cap_found;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             pos_lt_cnt;
		logic             pos_gt_cnt;
		logic             pos_eq_cnt;
		logic             pos_eq_last;
		logic             full;
		logic             empty;
		logic             more;
		logic             s1_valid;
		logic             match;
		logic             at_pos;
		logic             at_last;
	} sts_t;

endpackage

FILE: sv/ols_dp.sv
// ----------------------------------------------------------------------------
// ols_dp
// Datapath: request registers, entry memory with registered read, walk
// pointer, entry count and result registers.
// ----------------------------------------------------------------------------
module ols_dp import ols_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [ACT_W-1:0]        action,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output logic [STAT_W-1:0]       status,
	output logic signed [VAL_W-1:0] read_value,
	output logic [FIDX_W-1:0]       found_index,
	output logic [LEN_W-1:0]        list_length,
	output logic                    is_empty
);

	logic [VAL_W-1:0]        mem_q [CAPACITY];

	logic [ACT_W-1:0]        act_q;
	logic [POS_W-1:0]        pos_q;
	logic [VAL_W-1:0]        val_q;
	logic [CMP_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [VAL_W-1:0]        rdata_s1;
	logic [CMP_W-1:0]        ptr_s1;
	logic                    valid_s1;

	logic [STAT_W-1:0]       status_q;
	logic [VAL_W-1:0]        rd_val_q;
	logic [FIDX_W-1:0]       found_q;

	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [CMP_W-1:0]        cnt_last;
	logic [CMP_W-1:0]        ptr_up;
	logic [CMP_W-1:0]        ptr_dn;
	logic [CMP_W-1:0]        rd_addr_x;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [VAL_W-1:0]        wr_data;

	assign pos_x    = CMP_W'(pos_q);
	assign cnt_x    = CMP_W'(cnt_q);
	assign cnt_last = cnt_x - CMP_W'(1);
	assign ptr_up   = ptr_s1 + CMP_W'(1);
	assign ptr_dn   = ptr_s1 - CMP_W'(1);

	assign rd_addr_x = cmd.rd_sel_pos ? pos_x : ptr_q;
	assign rd_addr   = rd_addr_x[IDX_W-1:0];

	// a shift write only lands once its read data has arrived
	assign wr_en   = (cmd.wr_shift && valid_s1) || cmd.wr_val;
	assign wr_data = cmd.wr_val ? val_q : rdata_s1;

	always_comb begin
		if (cmd.wr_val) begin
			wr_addr = pos_x[IDX_W-1:0];
		end else if (cmd.wr_up) begin
			wr_addr = ptr_up[IDX_W-1:0];
		end else begin
			wr_addr = ptr_dn[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	// request, pointer and result registers
	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
		if (cmd.load) begin
			act_q    <= action;
			pos_q    <= position;
			val_q    <= value;
			status_q <= ST_OK;
			rd_val_q <= '0;
			found_q  <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.cap_read) begin
				rd_val_q <= rdata_s1;
			end
			if (cmd.cap_found) begin
				found_q <= ptr_s1[FIDX_W-1:0];
			end
		end
		case (cmd.ptr_op)
			PTR_ZERO: ptr_q <= '0;
			PTR_TOP:  ptr_q <= cnt_last;
			PTR_NEXT: ptr_q <= pos_x + CMP_W'(1);
			PTR_INC:  ptr_q <= ptr_q + CMP_W'(1);
			PTR_DEC:  ptr_q <= ptr_q - CMP_W'(1);
			default:  ptr_q <= ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			case (cmd.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC: cnt_q <= cnt_q - CNT_W'(1);
				CNT_CLR: cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_comb begin
		sts.act         = act_q;
		sts.pos_lt_cnt  = pos_x < cnt_x;
		sts.pos_gt_cnt  = pos_x > cnt_x;
		sts.pos_eq_cnt  = pos_x == cnt_x;
		sts.pos_eq_last = pos_x == cnt_last;
		sts.full        = cnt_x >= CMP_W'(CAPACITY);
		sts.empty       = cnt_q == '0;
		sts.more        = ptr_q < cnt_x;
		sts.s1_valid    = valid_s1;
		sts.match       = valid_s1 && (rdata_s1 == val_q);
		sts.at_pos      = ptr_q == pos_x;
		sts.at_last     = ptr_q == cnt_last;
	end

	assign status      = status_q;
	assign read_value  = rd_val_q;
	assign found_index = found_q;
	assign list_length = cnt_x[LEN_W-1:0];
	assign is_empty    = cnt_q == '0;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_val && cmd.wr_shift))
		else $error("value write and shift write in the same cycle");

endmodule

FILE: sv/ols_ctrl.sv
// ----------------------------------------------------------------------------
// ols_ctrl
// Controller: sequences each request through decide, memory walk and
// result cycles, driving the datapath by command word.
// ----------------------------------------------------------------------------
module ols_ctrl import ols_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = S_DONE;
				unique case (sts.act)
					ACT_GET: begin
						if (sts.pos_lt_cnt) begin
							state_nxt = S_GET_WAIT;
						end
					end
					ACT_LOCATE: begin
						if (!sts.empty) begin
							state_nxt = S_SCAN;
						end
					end
					ACT_INSERT: begin
						if (!sts.pos_gt_cnt && !sts.full) begin
							state_nxt = sts.pos_eq_cnt ? S_INS_VAL : S_INS;
						end
					end
					ACT_DELETE: begin
						if (!sts.empty && sts.pos_lt_cnt) begin
							state_nxt = sts.pos_eq_last ? S_DEL_DRAIN : S_DEL;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_GET_WAIT:  state_nxt = S_DONE;
			S_SCAN: begin
				if (sts.match || (!sts.more && !sts.s1_valid)) begin
					state_nxt = S_DONE;
				end
			end
			S_INS: begin
				if (sts.at_pos) begin
					state_nxt = S_INS_DRAIN;
				end
			end
			S_INS_DRAIN: state_nxt = S_INS_VAL;
			S_INS_VAL:   state_nxt = S_DONE;
			S_DEL: begin
				if (sts.at_last) begin
					state_nxt = S_DEL_DRAIN;
				end
			end
			S_DEL_DRAIN: state_nxt = S_DONE;
			S_DONE:      state_nxt = S_IDLE;
			default:     state_nxt = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd            = '0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.cnt_op     = CNT_HOLD;
		cmd.status     = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_DECIDE: begin
				unique case (sts.act)
					ACT_GET: begin
						if (sts.pos_lt_cnt) begin
							cmd.rd_en      = 1'b1;
							cmd.rd_sel_pos = 1'b1;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BAD_POS;
						end
					end
					ACT_LOCATE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NOT_FOUND;
						end else begin
							cmd.ptr_op = PTR_ZERO;
						end
					end
					ACT_INSERT: begin
						if (sts.pos_gt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BAD_POS;
						end else if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.ptr_op = PTR_TOP;
						end
					end
					ACT_DELETE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else if (!sts.pos_lt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BAD_POS;
						end else begin
							cmd.ptr_op = PTR_NEXT;
						end
					end
					ACT_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_BAD_POS;
					end
				endcase
			end
			S_GET_WAIT: begin
				cmd.cap_read = 1'b1;
			end
			S_SCAN: begin
				// stop issuing reads once a match is seen
				if (sts.match) begin
					cmd.cap_found = 1'b1;
				end else if (sts.more) begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end else if (!sts.s1_valid) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
				end
			end
			S_INS: begin
				cmd.rd_en    = 1'b1;
				cmd.ptr_op   = PTR_DEC;
				cmd.wr_shift = 1'b1;
				cmd.wr_up    = 1'b1;
			end
			S_INS_DRAIN: begin
				cmd.wr_shift = 1'b1;
				cmd.wr_up    = 1'b1;
			end
			S_INS_VAL: begin
				cmd.wr_val = 1'b1;
				cmd.cnt_op = CNT_INC;
			end
			S_DEL: begin
				cmd.rd_en    = 1'b1;
				cmd.ptr_op   = PTR_INC;
				cmd.wr_shift = 1'b1;
			end
			S_DEL_DRAIN: begin
				cmd.wr_shift = 1'b1;
				cmd.cnt_op   = CNT_DEC;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule

FILE: sv/ordered_list_store_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Fixed-capacity list of signed 32-bit entries with get, locate, insert,
// delete and clear requests, one result per request.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------
//   request   | start / busy         | action, position, value
//   result    | done (one cycle)     | status, read_value, found_index,
//             |                      | list_length, is_empty
//
// Clear and the error cases go from the decide state to the result; get
// adds a registered read of the entry. Locate walks up from the first
// entry until a match, insert down from the last entry to position, delete
// up from position to the last entry, one entry read and one written per
// cycle (locate only reads). busy is high from acceptance to the done cycle.
// The result must be taken in its done cycle. Reset empties the list at once;
// entries hold no reset value.
// ----------------------------------------------------------------------------
module ordered_list_store_unit import ols_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [ACT_W-1:0]        action,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic [STAT_W-1:0]       status,
	output logic signed [VAL_W-1:0] read_value,
	output logic [FIDX_W-1:0]       found_index,
	output logic [LEN_W-1:0]        list_length,
	output logic                    is_empty
);

	cmd_t cmd;
	sts_t sts;

	ols_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ols_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.position    (position),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.read_value  (read_value),
		.found_index (found_index),
		.list_length (list_length),
		.is_empty    (is_empty)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobed while idle");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((read_value == '0) && (found_index == '0)))
		else $error("failed request carries read data or index");

endmodule
